/* hw/rtl/bae_pkg.sv */
`default_nettype none

package bae_pkg;

    // Default sizes of the line store and the window.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_RADIUS_DEF = 3;

    // Field widths.
    localparam int DIM_W      = 12;
    localparam int RAD_W      = 2;
    localparam int COLOR_W    = 32;
    localparam int ALPHA_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Row counters hold one row beyond the frame; linear positions hold row times width.
    localparam int ROW_W = DIM_W + 1;
    localparam int LIN_W = ROW_W + DIM_W + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COLOR   = 2'd3;

    // Register reset values.
    localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 12'd480;
    localparam logic [RAD_W-1:0]   RADIUS_RST       = 2'd1;
    localparam logic [COLOR_W-1:0] KEEP_COLOR_RST   = 32'hFF00_0000;

    // Color of every pixel that does not survive.
    localparam logic [COLOR_W-1:0] TRANSPARENT_WHITE = 32'h00FF_FFFF;

    // Item kinds on the input stream.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Work handed from the position stage to the window stage.
    typedef struct packed {
        logic valid;
        logic pixel;
        logic alpha_on;
        logic fwd;
        logic emit;
        logic interior;
        logic last;
        logic clear;
    } t_win_cmd;

endpackage

`default_nettype wire

/* hw/rtl/bae_ram.sv */
`default_nettype none

module bae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/bae_ctrl.sv */
`default_nettype none

module bae_ctrl
    import bae_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [ALPHA_W-1:0]           i_s_tdata,
    input  wire logic                         i_s_tuser,
    input  wire logic                         i_en,
    output t_win_cmd                          o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_waddr,
    output logic                              o_re,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_raddr,
    output logic [RAD_W-1:0]                  o_radius,
    output logic [COLOR_W-1:0]                o_keep_color
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [5:0] {
        SEQ_IDLE = 6'b000001,
        SEQ_IN   = 6'b000010,
        SEQ_OUT  = 6'b000100,
        SEQ_RAD  = 6'b001000,
        SEQ_AREA = 6'b010000,
        SEQ_DONE = 6'b100000
    } t_seq_state;

    // Configuration registers.
    logic [DIM_W-1:0]   r_cfg_width;
    logic [DIM_W-1:0]   r_cfg_height;
    logic [RAD_W-1:0]   r_cfg_radius;
    logic [COLOR_W-1:0] r_keep_color;

    // Position state.
    logic [DIM_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [DIM_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [LIN_W-1:0] r_lin_in,  n_lin_in;
    logic [LIN_W-1:0] r_lin_out, n_lin_out;
    logic [LIN_W-1:0] r_delay,   n_delay;
    logic [LIN_W-1:0] r_total,   n_total;
    logic [LIN_W-1:0] r_prod,    n_prod;
    t_seq_state       r_seq,     n_seq;
    logic             r_pending, n_pending;
    t_win_cmd         r_cmd,     n_cmd;
    logic [DIM_W-1:0] r_b_col,   n_b_col;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [RAD_W-1:0] r_eff;

    logic                   in_wrap, out_wrap;
    logic [DIM_W-1:0]       in_col_w, out_col_w;
    logic [ROW_W-1:0]       in_row_w, out_row_w;
    logic [ROW_W-1:0]       mul_a;
    logic [ROW_W+DIM_W-1:0] mul_p;

    logic             accept;
    logic             in_done;
    logic             is_pixel;
    logic [DIM_W-1:0] in_col_inc;
    logic [DIM_W-1:0] out_col_inc;
    logic [LIN_W-1:0] lin_in_inc;
    logic [LIN_W-1:0] lin_out_inc;
    logic             emit_due;
    logic             interior;
    logic             is_last;
    t_win_cmd         cmd_a;

    // Effective frame size and radius after the saturation rules.
    always_comb begin
        w_eff = r_cfg_width;
        if (r_cfg_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = (r_cfg_height == '0) ? DIM_W'(1) : r_cfg_height;
        r_eff = (32'(r_cfg_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_cfg_radius;
    end

    // Columns left outside a narrowed frame move to the start of the next row.
    assign in_wrap   = r_in_col >= w_eff;
    assign out_wrap  = r_out_col >= w_eff;
    assign in_col_w  = in_wrap ? '0 : r_in_col;
    assign out_col_w = out_wrap ? '0 : r_out_col;
    assign in_row_w  = r_in_row + ROW_W'(in_wrap);
    assign out_row_w = r_out_row + ROW_W'(out_wrap);

    // Shared multiplier for rebuilding positions after a configuration change.
    always_comb begin
        unique case (r_seq)
            SEQ_IN:   mul_a = in_row_w;
            SEQ_OUT:  mul_a = out_row_w;
            SEQ_RAD:  mul_a = ROW_W'(r_eff);
            SEQ_AREA: mul_a = ROW_W'(h_eff);
            default:  mul_a = '0;
        endcase
    end
    assign mul_p = mul_a * w_eff;

    // Decisions for the item offered on the input.
    assign accept      = i_s_tvalid && o_s_tready;
    assign in_done     = r_in_row >= ROW_W'(h_eff);
    assign is_pixel    = (i_s_tuser == CMD_PIXEL);
    assign in_col_inc  = r_in_col + DIM_W'(1);
    assign out_col_inc = r_out_col + DIM_W'(1);
    assign lin_in_inc  = r_lin_in + LIN_W'(1);
    assign lin_out_inc = r_lin_out + LIN_W'(1);
    assign emit_due    = lin_in_inc > (r_lin_out + r_delay);
    assign is_last     = lin_out_inc >= r_total;
    assign interior    = (r_out_row >= ROW_W'(r_eff))
                      && ((r_out_row + ROW_W'(r_eff)) < ROW_W'(h_eff))
                      && (r_out_col >= DIM_W'(r_eff))
                      && (({1'b0, r_out_col} + (DIM_W + 1)'(r_eff)) < {1'b0, w_eff});

    // Next state of the position counters, the rebuild sequencer and the stage register.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lin_in  = r_lin_in;
        n_lin_out = r_lin_out;
        n_delay   = r_delay;
        n_total   = r_total;
        n_prod    = LIN_W'(mul_p);
        n_seq     = r_seq;
        n_pending = r_pending;
        n_cmd     = r_cmd;
        n_b_col   = r_b_col;
        cmd_a     = '0;

        // Rebuild linear positions, output delay and frame size, one product a cycle.
        unique case (r_seq)
            SEQ_IDLE: begin
                if (r_pending && i_s_tvalid) begin
                    n_seq = SEQ_IN;
                end
            end
            SEQ_IN: begin
                n_seq = SEQ_OUT;
            end
            SEQ_OUT: begin
                n_lin_in = r_prod + LIN_W'(in_col_w);
                n_seq    = SEQ_RAD;
            end
            SEQ_RAD: begin
                n_lin_out = r_prod + LIN_W'(out_col_w);
                n_seq     = SEQ_AREA;
            end
            SEQ_AREA: begin
                n_delay = r_prod + LIN_W'(r_eff);
                n_seq   = SEQ_DONE;
            end
            SEQ_DONE: begin
                n_total   = r_prod;
                n_in_col  = in_col_w;
                n_in_row  = in_row_w;
                n_out_col = out_col_w;
                n_out_row = out_row_w;
                n_pending = 1'b0;
                n_seq     = SEQ_IDLE;
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase

        // Input transfer: advance the counters and decide on a result.
        if (accept) begin
            cmd_a.valid = 1'b1;
            if (in_done) begin
                if (r_lin_out >= r_total) begin
                    cmd_a.clear = 1'b1;
                end else begin
                    cmd_a.emit = 1'b1;
                end
            end else if (is_pixel) begin
                cmd_a.pixel    = 1'b1;
                cmd_a.alpha_on = (i_s_tdata != '0);
                cmd_a.fwd      = r_cmd.valid && r_cmd.pixel && (r_b_col == r_in_col);
                n_b_col        = r_in_col;
                n_lin_in       = lin_in_inc;
                if (in_col_inc >= w_eff) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = in_col_inc;
                end
                if (emit_due) begin
                    cmd_a.emit     = 1'b1;
                    cmd_a.interior = interior;
                end
            end

            if (cmd_a.emit) begin
                if (is_last) begin
                    cmd_a.last  = 1'b1;
                    cmd_a.clear = 1'b1;
                end else begin
                    n_lin_out = lin_out_inc;
                    if (out_col_inc >= w_eff) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + ROW_W'(1);
                    end else begin
                        n_out_col = out_col_inc;
                    end
                end
            end

            // End of frame: every position starts over.
            if (cmd_a.clear) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_lin_in  = '0;
                n_lin_out = '0;
            end
        end

        if (i_en) begin
            n_cmd = cmd_a;
        end

        // A configuration write invalidates the derived positions.
        if (i_cfg_valid) begin
            n_pending = 1'b1;
            n_seq     = SEQ_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lin_in  <= '0;
            r_lin_out <= '0;
            r_delay   <= '0;
            r_total   <= '0;
            r_seq     <= SEQ_IDLE;
            r_pending <= 1'b1;
            r_cmd     <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lin_in  <= n_lin_in;
            r_lin_out <= n_lin_out;
            r_delay   <= n_delay;
            r_total   <= n_total;
            r_seq     <= n_seq;
            r_pending <= n_pending;
            r_cmd     <= n_cmd;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_b_col <= n_b_col;
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= FRAME_WIDTH_RST;
            r_cfg_height <= FRAME_HEIGHT_RST;
            r_cfg_radius <= RADIUS_RST;
            r_keep_color <= KEEP_COLOR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[DIM_W-1:0];
                REG_RADIUS:       r_cfg_radius <= i_cfg_data[RAD_W-1:0];
                REG_KEEP_COLOR:   r_keep_color <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_s_tready   = i_en && !r_pending;
    assign o_cmd        = r_cmd;
    assign o_waddr      = AW'(r_b_col);
    assign o_re         = accept && !in_done && is_pixel;
    assign o_raddr      = AW'(r_in_col);
    assign o_radius     = r_eff;
    assign o_keep_color = r_keep_color;

endmodule

`default_nettype wire

/* hw/rtl/bae_win.sv */
`default_nettype none

module bae_win
    import bae_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_win_cmd                i_cmd,
    input  wire logic [2*MAX_RADIUS-1:0] i_rdata,
    input  wire logic [RAD_W-1:0]        i_radius,
    input  wire logic [COLOR_W-1:0]      i_keep_color,
    input  wire logic                    i_m_tready,
    output logic                         o_en,
    output logic                         o_we,
    output logic [2*MAX_RADIUS-1:0]      o_wdata,
    output logic                         o_m_tvalid,
    output logic [COLOR_W-1:0]           o_m_tdata,
    output logic                         o_m_tlast
);

    localparam int HW = 2 * MAX_RADIUS;
    localparam int WS = HW + 1;

    // Earlier column vectors of the window, newest first.
    logic [WS-1:0]      r_win [HW];
    logic [HW-1:0]      r_fwd_vec;
    logic               r_m_tvalid;
    logic [COLOR_W-1:0] r_m_tdata;
    logic               r_m_tlast;

    logic [HW-1:0] hist;
    logic [WS-1:0] vec;
    logic [WS-1:0] mask;
    logic [WS-1:0] win_all [WS];
    logic          full;
    logic          consume;

    // Column vector of the current pixel: its own bit below the rows above it.
    assign hist = i_cmd.fwd ? r_fwd_vec : i_rdata;
    assign vec  = {hist, i_cmd.alpha_on};

    assign win_all[0] = vec;
    for (genvar k = 1; k < WS; k++) begin : g_win_all
        assign win_all[k] = r_win[k-1];
    end

    // Every column of the active window must be solid over the active rows.
    always_comb begin
        for (int j = 0; j < WS; j++) begin
            mask[j] = (j <= 2 * int'(i_radius));
        end
        full = 1'b1;
        for (int k = 0; k < WS; k++) begin
            if ((k <= 2 * int'(i_radius)) && ((win_all[k] & mask) != mask)) begin
                full = 1'b0;
            end
        end
    end

    // The stage moves on unless its result finds the output register occupied.
    assign o_en    = !(i_cmd.valid && i_cmd.emit && r_m_tvalid && !i_m_tready);
    assign consume = o_en && i_cmd.valid;
    assign o_we    = consume && i_cmd.pixel;
    assign o_wdata = vec[HW-1:0];

    // Window shift, end-of-frame clear and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HW; k++) begin
                r_win[k] <= '0;
            end
            r_m_tvalid <= 1'b0;
        end else begin
            if (consume && i_cmd.pixel) begin
                r_win[0] <= vec;
                for (int k = 1; k < HW; k++) begin
                    r_win[k] <= r_win[k-1];
                end
            end
            if (consume && i_cmd.clear) begin
                for (int k = 0; k < HW; k++) begin
                    r_win[k] <= '0;
                end
            end
            if (consume && i_cmd.emit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Result payload and the bypass copy of the last row-store write.
    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_fwd_vec <= vec[HW-1:0];
        end
        if (consume && i_cmd.emit) begin
            r_m_tdata <= (i_cmd.interior && full) ? i_keep_color : TRANSPARENT_WHITE;
            r_m_tlast <= i_cmd.last;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

endmodule

`default_nettype wire

/* hw/rtl/binary_alpha_erosion.sv */
`default_nettype none

// Binary erosion of an alpha stream with a square window of radius 0 to 3. Pixels arrive in
// raster order with tuser low; a pixel leaves as keep_color when it and every pixel of the
// window around it have nonzero alpha, otherwise as transparent white, and tlast marks the
// final pixel of the frame. Results trail the input by radius rows plus radius pixels; after
// the last pixel of a frame, send flush items (tuser high) to drain the remaining outputs.
// The block takes one item per clock as long as the output side accepts results, and a
// result passes the stage register on its way to the output register (the row-store read
// is issued at the transfer, the window check runs in the next cycle). After reset and
// after every configuration write the next item waits while a single shared multiplier
// rebuilds the linear positions, the output delay and the frame size. The row store needs
// no clearing pass after reset.
module binary_alpha_erosion
    import bae_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [ALPHA_W-1:0]    i_s_tdata,   // [7:0] alpha
    input  wire logic                  i_s_tuser,   // [0] command: 0 pixel, 1 flush
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [COLOR_W-1:0]         o_m_tdata,   // [31:0] pixel_argb
    output logic                       o_m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = 2 * MAX_RADIUS;

    t_win_cmd           cmd;
    logic               en;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [HW-1:0]      wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [HW-1:0]      rdata;
    logic [RAD_W-1:0]   radius;
    logic [COLOR_W-1:0] keep_color;

    // Positions, configuration and the row-store read.
    bae_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_en         (en),
        .o_cmd        (cmd),
        .o_waddr      (waddr),
        .o_re         (re),
        .o_raddr      (raddr),
        .o_radius     (radius),
        .o_keep_color (keep_color)
    );

    // Alpha history of the rows above, one column vector per entry.
    bae_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Window update, erosion test and output register.
    bae_win #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_win (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rdata      (rdata),
        .i_radius     (radius),
        .i_keep_color (keep_color),
        .i_m_tready   (i_m_tready),
        .o_en         (en),
        .o_we         (we),
        .o_wdata      (wdata),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

endmodule

`default_nettype wire
